@@ hdl/bpmc_pkg.sv @@
// Shared types, codes and constants for the bad pixel mask classifier.
package bpmc_pkg;

  // Default widths of the pixel fields
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths of the register set
  localparam int COORD_W_MAX = 16;
  localparam int THR_W       = 32;
  localparam int EDGE_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int FRAC_BITS   = 8;

  // Result word: is_bad in tdata, cause in tuser
  localparam int OUT_TDATA_W = 8;
  localparam int CAUSE_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANEL_BAD   = 3'd0,
    CFG_FLAG_MODE_A = 3'd1,
    CFG_FLAG_VAL_A  = 3'd2,
    CFG_FLAG_MODE_B = 3'd3,
    CFG_FLAG_VAL_B  = 3'd4,
    CFG_EDGE_WIDTH  = 3'd5,
    CFG_PANEL_SIZE  = 3'd6,
    CFG_REGION      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FLAG_NONE = 2'd0,
    FLAG_LT   = 2'd1,
    FLAG_GT   = 2'd2,
    FLAG_EQ   = 2'd3
  } flag_mode_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_GOOD   = 3'd0,
    CAUSE_PRIOR  = 3'd1,
    CAUSE_PANEL  = 3'd2,
    CAUSE_FLAG   = 3'd3,
    CAUSE_EDGE   = 3'd4,
    CAUSE_REGION = 3'd5
  } cause_t;

  // Live register set; coordinate fields hold the low COORD_BITS, zero-extended
  typedef struct packed {
    logic                          panel_bad;
    flag_mode_t                    mode_a;
    logic signed [THR_W-1:0]       thr_a;
    flag_mode_t                    mode_b;
    logic signed [THR_W-1:0]       thr_b;
    logic [EDGE_W-1:0]             edge_w;
    logic [COORD_W_MAX-1:0]        width;
    logic [COORD_W_MAX-1:0]        height;
    logic [COORD_W_MAX-1:0]        min_fs;
    logic [COORD_W_MAX-1:0]        max_fs;
    logic [COORD_W_MAX-1:0]        min_ss;
    logic [COORD_W_MAX-1:0]        max_ss;
  } cfg_t;

endpackage

@@ hdl/bpmc_cfg.sv @@
// Configuration register file of the bad pixel mask classifier.
module bpmc_cfg
  import bpmc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic                    panel_bad_r;
  flag_mode_t              mode_a_r;
  logic [THR_W-1:0]        thr_a_r;
  flag_mode_t              mode_b_r;
  logic [THR_W-1:0]        thr_b_r;
  logic [EDGE_W-1:0]       edge_w_r;
  logic [COORD_BITS-1:0]   width_r;
  logic [COORD_BITS-1:0]   height_r;
  logic [COORD_BITS-1:0]   min_fs_r;
  logic [COORD_BITS-1:0]   max_fs_r;
  logic [COORD_BITS-1:0]   min_ss_r;
  logic [COORD_BITS-1:0]   max_ss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_bad_r <= 1'b0;
      mode_a_r    <= FLAG_NONE;
      thr_a_r     <= '0;
      mode_b_r    <= FLAG_NONE;
      thr_b_r     <= '0;
      edge_w_r    <= '0;
      width_r     <= '0;
      height_r    <= '0;
      // empty region: min_fs above max_fs
      min_fs_r    <= '1;
      max_fs_r    <= '0;
      min_ss_r    <= '0;
      max_ss_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PANEL_BAD:   panel_bad_r <= cfg_data[0];
        CFG_FLAG_MODE_A: mode_a_r    <= flag_mode_t'(cfg_data[1:0]);
        CFG_FLAG_VAL_A:  thr_a_r     <= cfg_data[THR_W-1:0];
        CFG_FLAG_MODE_B: mode_b_r    <= flag_mode_t'(cfg_data[1:0]);
        CFG_FLAG_VAL_B:  thr_b_r     <= cfg_data[THR_W-1:0];
        CFG_EDGE_WIDTH:  edge_w_r    <= cfg_data[EDGE_W-1:0];
        CFG_PANEL_SIZE: begin
          width_r  <= cfg_data[COORD_BITS-1:0];
          height_r <= cfg_data[16 +: COORD_BITS];
        end
        CFG_REGION: begin
          min_fs_r <= cfg_data[COORD_BITS-1:0];
          max_fs_r <= cfg_data[16 +: COORD_BITS];
          min_ss_r <= cfg_data[32 +: COORD_BITS];
          max_ss_r <= cfg_data[48 +: COORD_BITS];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.panel_bad = panel_bad_r;
    cfg.mode_a    = mode_a_r;
    cfg.thr_a     = thr_a_r;
    cfg.mode_b    = mode_b_r;
    cfg.thr_b     = thr_b_r;
    cfg.edge_w    = edge_w_r;
    cfg.width     = COORD_W_MAX'(width_r);
    cfg.height    = COORD_W_MAX'(height_r);
    cfg.min_fs    = COORD_W_MAX'(min_fs_r);
    cfg.max_fs    = COORD_W_MAX'(max_fs_r);
    cfg.min_ss    = COORD_W_MAX'(min_ss_r);
    cfg.max_ss    = COORD_W_MAX'(max_ss_r);
  end

endmodule

@@ hdl/bpmc_flag.sv @@
// One flag slot test: less than, more than, or equal after round-half-even.
module bpmc_flag
  import bpmc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  flag_mode_t                     mode,
  input  logic signed [THR_W-1:0]        thr,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           hit
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int Q_W   = CMP_W - FRAC_BITS;

  logic signed [CMP_W-1:0] s_x;
  logic signed [CMP_W-1:0] t_x;
  logic [FRAC_BITS-1:0]    frac;
  logic [Q_W-1:0]          q;
  logic                    inc;
  logic [Q_W:0]            rq;
  logic [Q_W:0]            tq;
  logic                    eq;

  assign s_x  = CMP_W'(sample);
  assign t_x  = CMP_W'(thr);
  assign frac = s_x[FRAC_BITS-1:0];
  assign q    = s_x[CMP_W-1:FRAC_BITS];
  // round up above one half, and at one half only from an odd integer
  assign inc  = (frac > 8'd128) || ((frac == 8'd128) && q[0]);
  assign rq   = {q[Q_W-1], q} + (Q_W+1)'(inc);
  assign tq   = {t_x[CMP_W-1], t_x[CMP_W-1:FRAC_BITS]};
  // a threshold with a fraction never equals a rounded sample
  assign eq   = (t_x[FRAC_BITS-1:0] == '0) && (rq == tq);

  always_comb begin
    unique case (mode)
      FLAG_LT: hit = s_x < t_x;
      FLAG_GT: hit = s_x > t_x;
      FLAG_EQ: hit = eq;
      default: hit = 1'b0;
    endcase
  end

endmodule

@@ hdl/bad_pixel_mask_classifier.sv @@
// Top level of the bad pixel mask classifier: register file and pixel pipeline.
//
// Each input word is one pixel of a panel; each pixel gives exactly one result
// word: is_bad and a cause code (prior mark, bad panel, flag slot hit, border
// edge, bad region, else good), the first match in that order winning. One pixel
// is accepted every clock cycle while out_tready does not stall the pipeline. The
// pixel passes four register stages (input register, test stage, distance
// reduction, output register) before its result word is presented on the output.
// A stall on out_tready backs the pipeline up without loss.
// The register file takes a write every cycle and must only be written while
// no pixel is in flight. Panel size, region bounds and the flag thresholds
// take effect for the next pixel accepted after the write.
module bad_pixel_mask_classifier
  import bpmc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fast_coord, slow_coord, sample (low bit up), zero padded to bytes
  input  logic [((2*COORD_BITS+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // prior_bad
  input  logic                  in_tuser,
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // is_bad, zero padded to a byte
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // cause
  output logic [CAUSE_W-1:0]    out_tuser,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int C = COORD_BITS;

  cfg_t cfg;

  bpmc_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [C-1:0] w;
  logic [C-1:0] h;
  assign w = cfg.width[C-1:0];
  assign h = cfg.height[C-1:0];

  // Stage valids and the backward ready chain
  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_b, rdy_c, rdy_d;

  assign rdy_d     = !vd_r || out_tready;
  assign rdy_c     = !vc_r || rdy_d;
  assign rdy_b     = !vb_r || rdy_c;
  assign in_tready = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (in_tready) va_r <= in_tvalid;
      if (rdy_b)     vb_r <= va_r;
      if (rdy_c)     vc_r <= vb_r;
      if (rdy_d)     vd_r <= vc_r;
    end
  end

  // Stage A: capture the pixel word
  logic [C-1:0]                  fs_a_r;
  logic [C-1:0]                  ss_a_r;
  logic signed [SAMPLE_BITS-1:0] smp_a_r;
  logic                          prior_a_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      fs_a_r    <= in_tdata[C-1:0];
      ss_a_r    <= in_tdata[C +: C];
      smp_a_r   <= in_tdata[2*C +: SAMPLE_BITS];
      prior_a_r <= in_tuser;
    end
  end

  // Stage B: flag slots, border distances, clamped edge width, region test
  logic hit_a, hit_b;

  bpmc_flag #(.SAMPLE_BITS(SAMPLE_BITS)) u_flag_a (
    .mode   (cfg.mode_a),
    .thr    (cfg.thr_a),
    .sample (smp_a_r),
    .hit    (hit_a)
  );

  bpmc_flag #(.SAMPLE_BITS(SAMPLE_BITS)) u_flag_b (
    .mode   (cfg.mode_b),
    .thr    (cfg.thr_b),
    .sample (smp_a_r),
    .hit    (hit_b)
  );

  logic              inside_a;
  logic [EDGE_W-1:0] e_w1;
  logic [EDGE_W-1:0] e_w2;
  logic              region_a;

  always_comb begin
    inside_a = (fs_a_r < w) && (ss_a_r < h);
    // clamp against width first, then height
    if (cfg.edge_w > EDGE_W'(w)) e_w1 = EDGE_W'(w >> 1) + EDGE_W'(1);
    else                         e_w1 = cfg.edge_w;
    if (e_w1 > EDGE_W'(h))       e_w2 = EDGE_W'(h >> 1) + EDGE_W'(1);
    else                         e_w2 = e_w1;
    // a region reaching outside the panel is ignored
    region_a = (cfg.max_fs[C-1:0] < w) && (cfg.max_ss[C-1:0] < h)
            && (fs_a_r >= cfg.min_fs[C-1:0]) && (fs_a_r <= cfg.max_fs[C-1:0])
            && (ss_a_r >= cfg.min_ss[C-1:0]) && (ss_a_r <= cfg.max_ss[C-1:0]);
  end

  logic              prior_b_r;
  logic              flag_b_r;
  logic              edge_on_b_r;
  logic              region_b_r;
  logic [EDGE_W-1:0] e_b_r;
  logic [C-1:0]      fs_b_r, ss_b_r, dw_b_r, dh_b_r;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      prior_b_r   <= prior_a_r;
      flag_b_r    <= hit_a || hit_b;
      edge_on_b_r <= (cfg.edge_w != '0) && inside_a;
      region_b_r  <= region_a;
      e_b_r       <= e_w2;
      fs_b_r      <= fs_a_r;
      ss_b_r      <= ss_a_r;
      // only meaningful for a pixel inside the panel
      dw_b_r      <= w - C'(1) - fs_a_r;
      dh_b_r      <= h - C'(1) - ss_a_r;
    end
  end

  // Stage C: first level of the nearest-border minimum
  logic              prior_c_r;
  logic              flag_c_r;
  logic              edge_on_c_r;
  logic              region_c_r;
  logic [EDGE_W-1:0] e_c_r;
  logic [C-1:0]      m1_c_r, m2_c_r;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      prior_c_r   <= prior_b_r;
      flag_c_r    <= flag_b_r;
      edge_on_c_r <= edge_on_b_r;
      region_c_r  <= region_b_r;
      e_c_r       <= e_b_r;
      m1_c_r      <= (fs_b_r < ss_b_r) ? fs_b_r : ss_b_r;
      m2_c_r      <= (dw_b_r < dh_b_r) ? dw_b_r : dh_b_r;
    end
  end

  // Stage D: last minimum, edge compare, cause priority into the output register
  logic [C-1:0] d_c;
  logic         edge_hit_c;
  cause_t       cause_c;

  always_comb begin
    d_c        = (m1_c_r < m2_c_r) ? m1_c_r : m2_c_r;
    edge_hit_c = edge_on_c_r && (EDGE_W'(d_c) < e_c_r);
    if (prior_c_r)            cause_c = CAUSE_PRIOR;
    else if (cfg.panel_bad)   cause_c = CAUSE_PANEL;
    else if (flag_c_r)        cause_c = CAUSE_FLAG;
    else if (edge_hit_c)      cause_c = CAUSE_EDGE;
    else if (region_c_r)      cause_c = CAUSE_REGION;
    else                      cause_c = CAUSE_GOOD;
  end

  cause_t cause_d_r;

  always_ff @(posedge clk) begin
    if (rdy_d) cause_d_r <= cause_c;
  end

  assign out_tvalid = vd_r;
  assign out_tuser  = cause_d_r;
  assign out_tdata  = OUT_TDATA_W'(cause_d_r != CAUSE_GOOD);

  // is_bad and cause agree on every result word
  a_bad_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tuser != CAUSE_GOOD)))
    else $error("is_bad disagrees with cause");

  // no cause code beyond the region code
  a_cause_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= CAUSE_REGION))
    else $error("cause code out of range");

  // a held pixel in the input stage is not dropped
  a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !rdy_b) |=> va_r)
    else $error("input stage lost a pixel");

  // a bad panel overrides every test except the prior mark
  a_panel_wins: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && rdy_d && !prior_c_r && cfg.panel_bad) |=> (out_tuser == CAUSE_PANEL))
    else $error("bad panel not reported");

endmodule
